/* hdl/ovjr_pkg.sv */
// Shared types and constants for the overwriting event journal ring.
`default_nettype none

package ovjr_pkg;

    localparam int CAP_W     = 7;
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 3 * WORD_W;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TYPE_MASK  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEBUG_TYPE = 2'd2;

    localparam logic ACT_LOG  = 1'b0;
    localparam logic ACT_PLAY = 1'b1;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET   = 7'd0;
    localparam logic [WORD_W-1:0] TYPE_MASK_RESET  = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] DEBUG_TYPE_RESET = 32'h0000_0003;

    typedef struct packed {
        logic log;
        logic play_start;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_status;

endpackage

`default_nettype wire

/* hdl/ovjr_ctrl.sv */
// Controller state machine that sequences logging and playback.
`default_nettype none

module ovjr_ctrl import ovjr_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  wire     i_action,
    input  wire     i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PLAY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_stall       = 1'b1;
        o_out_valid      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == ACT_PLAY) begin
                        if (!i_status.empty) begin
                            o_cmd.play_start = 1'b1;
                            n_state          = S_PLAY;
                        end
                    end else begin
                        o_cmd.log = 1'b1;
                    end
                end
            end
            S_PLAY: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/ovjr_datapath.sv */
// Datapath with registers, ring pointers and the journal memory.
`default_nettype none

module ovjr_datapath import ovjr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [REG_IDX_W-1:0]  i_cfg_index,
    input  wire [WORD_W-1:0]     i_cfg_data,
    input  wire [WORD_W-1:0]     i_code_type,
    input  wire [WORD_W-1:0]     i_code_value,
    input  wire [WORD_W-1:0]     i_instance_number,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic [WORD_W-1:0]    o_entry_type,
    output logic [WORD_W-1:0]    o_entry_value,
    output logic [WORD_W-1:0]    o_entry_instance
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = ($clog2(DEPTH + 1) > CAP_W) ? $clog2(DEPTH + 1) : CAP_W;

    logic [CAP_W-1:0]   r_capacity;
    logic [WORD_W-1:0]  r_type_mask;
    logic [WORD_W-1:0]  r_debug_type;
    logic [PW-1:0]      r_oldest;
    logic [PW-1:0]      r_write;
    logic [PW-1:0]      r_pos;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_mem [DEPTH];

    logic [CW-1:0] cap_ext;
    logic [CW-1:0] eff_cap;
    logic [PW-1:0] write_next;
    logic [PW-1:0] oldest_next;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] rd_addr;
    logic          rd_en;
    logic          log_take;

    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p, input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(p) + CW'(1);
        return (inc == cap) ? '0 : inc[PW-1:0];
    endfunction

    assign cap_ext     = CW'(r_capacity);
    assign eff_cap     = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
    assign write_next  = f_wrap(r_write, eff_cap);
    assign oldest_next = f_wrap(r_oldest, eff_cap);
    assign pos_next    = f_wrap(r_pos, eff_cap);

    assign log_take = i_cmd.log && ((i_code_type & r_type_mask) != r_debug_type)
                      && (eff_cap != '0);
    assign rd_en    = i_cmd.play_start || i_cmd.advance;
    assign rd_addr  = i_cmd.play_start ? r_oldest : pos_next;

    assign o_status.empty = (r_oldest == r_write);
    assign o_status.last  = (pos_next == r_write);

    assign o_entry_type     = r_rd_data[ENTRY_W-1 -: WORD_W];
    assign o_entry_value    = r_rd_data[2*WORD_W-1 -: WORD_W];
    assign o_entry_instance = r_rd_data[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RESET;
            r_type_mask  <= TYPE_MASK_RESET;
            r_debug_type <= DEBUG_TYPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CAPACITY:   r_capacity   <= i_cfg_data[CAP_W-1:0];
                REG_TYPE_MASK:  r_type_mask  <= i_cfg_data;
                REG_DEBUG_TYPE: r_debug_type <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_write  <= '0;
        end else if (i_cfg_we && (i_cfg_index == REG_CAPACITY)) begin
            r_oldest <= '0;
            r_write  <= '0;
        end else if (log_take) begin
            r_write <= write_next;
            if (write_next == r_oldest) begin
                r_oldest <= oldest_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.play_start) begin
            r_pos <= r_oldest;
        end else if (i_cmd.advance) begin
            r_pos <= pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (log_take) begin
            r_mem[r_write] <= {i_code_type, i_code_value, i_instance_number};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/overwriting_event_journal_ring_unit.sv */
// Top level of the overwriting event journal ring.
`default_nettype none

// A log item leaves the unit idle, so a new item may follow in the next cycle. A playback
// item that finds N held entries returns them oldest first, each held while the output is
// stalled, with last_of_run on the newest entry, read through the single read port of the
// journal memory as it walks the ring. An empty ring answers a playback item with nothing.
// Writing the capacity register empties the ring; configuration is always ready.
module overwriting_event_journal_ring_unit import ovjr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [REG_IDX_W-1:0]  i_cfg_index,
    input  wire [WORD_W-1:0]     i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire                  i_action,
    input  wire [WORD_W-1:0]     i_code_type,
    input  wire [WORD_W-1:0]     i_code_value,
    input  wire [WORD_W-1:0]     i_instance_number,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [WORD_W-1:0]    o_entry_type,
    output logic [WORD_W-1:0]    o_entry_value,
    output logic [WORD_W-1:0]    o_entry_instance,
    output logic                 o_last_of_run
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready   = 1'b1;
    assign o_last_of_run = status.last;

    ovjr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ovjr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_code_type       (i_code_type),
        .i_code_value      (i_code_value),
        .i_instance_number (i_instance_number),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_entry_type      (o_entry_type),
        .o_entry_value     (o_entry_value),
        .o_entry_instance  (o_entry_instance)
    );

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("An item was offered for input during playback.");

    a_log_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_LOG)) |=> !o_in_stall)
        else $error("A log item did not finish in one cycle.");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_of_run) |=> !o_out_valid)
        else $error("Playback continued past the newest entry.");

    a_play_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.play_start) |=> (o_out_valid && !status.empty))
        else $error("Playback started without a held entry.");

endmodule

`default_nettype wire

/* tb/tb_overwriting_event_journal_ring_unit.sv */
// Self-checking testbench for the overwriting event journal ring: directed table, then random phases.
`timescale 1ns / 1ps

module tb_overwriting_event_journal_ring_unit;
    import ovjr_pkg::*;

    localparam int JOURNAL_DEPTH  = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] etype;
        logic [WORD_W-1:0] evalue;
        logic [WORD_W-1:0] einst;
        logic              last;
    } t_journal_entry;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOG, ROW_PLAY} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_row_check;

    typedef struct packed {
        t_row_kind             kind;
        t_row_check            chk;
        logic [REG_IDX_W-1:0]  idx;
        logic [WORD_W-1:0]     w0;
        logic [WORD_W-1:0]     w1;
        logic [WORD_W-1:0]     w2;
    } t_stim_row;

    localparam int N_ROWS = 33;

    t_stim_row directed_rows [N_ROWS] = '{
        '{ROW_PLAY, CHK_NONE,  REG_CAPACITY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
        '{ROW_PLAY, CHK_NONE,  REG_CAPACITY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_CAPACITY,   32'h0000_0001, 32'h0000_0000, 32'h0000_0000},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F},
        '{ROW_PLAY, CHK_NONE,  REG_CAPACITY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FF82, 32'h0000_0000, 32'h0000_0000},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
        '{ROW_PLAY, CHK_ONE,   REG_CAPACITY,   32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FF03, 32'h0000_0001, 32'h0000_0001},
        '{ROW_PLAY, CHK_ONE,   REG_CAPACITY,   32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
        '{ROW_PLAY, CHK_ONE,   REG_CAPACITY,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_TYPE_MASK,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_DEBUG_TYPE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_CAPACITY,   32'h0000_007F, 32'h0000_0000, 32'h0000_0000},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h0000_00FF, 32'h5555_5555, 32'hAAAA_AAAA},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h0000_0003, 32'h0000_0001, 32'h0000_0002},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF},
        '{ROW_PLAY, CHK_MODEL, REG_CAPACITY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_SPARE,      32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_TYPE_MASK,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_DEBUG_TYPE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_CAPACITY,   32'h0000_0041, 32'h0000_0000, 32'h0000_0000},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h1234_5678, 32'h0000_0001, 32'h0000_0002},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0004},
        '{ROW_PLAY, CHK_NONE,  REG_CAPACITY,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_TYPE_MASK,  32'h0000_00FF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_DEBUG_TYPE, 32'h0000_0003, 32'h0000_0000, 32'h0000_0000},
        '{ROW_CFG,  CHK_MODEL, REG_CAPACITY,   32'hFFFF_FFC0, 32'h0000_0000, 32'h0000_0000},
        '{ROW_LOG,  CHK_MODEL, REG_CAPACITY,   32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{ROW_PLAY, CHK_ONE,   REG_CAPACITY,   32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index = REG_CAPACITY;
    logic [WORD_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_action = ACT_LOG;
    logic [WORD_W-1:0]    i_code_type = '0;
    logic [WORD_W-1:0]    i_code_value = '0;
    logic [WORD_W-1:0]    i_instance_number = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_W-1:0]    o_entry_type;
    logic [WORD_W-1:0]    o_entry_value;
    logic [WORD_W-1:0]    o_entry_instance;
    logic                 o_last_of_run;

    overwriting_event_journal_ring_unit #(
        .DEPTH(JOURNAL_DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_code_type      (i_code_type),
        .i_code_value     (i_code_value),
        .i_instance_number(i_instance_number),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_entry_type     (o_entry_type),
        .o_entry_value    (o_entry_value),
        .o_entry_instance (o_entry_instance),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the journal and its registers.
    logic [WORD_W-1:0] shadow_type  [JOURNAL_DEPTH];
    logic [WORD_W-1:0] shadow_value [JOURNAL_DEPTH];
    logic [WORD_W-1:0] shadow_inst  [JOURNAL_DEPTH];
    int unsigned       oldest_ptr = 0;
    int unsigned       write_ptr = 0;
    logic [CAP_W-1:0]  capacity_q = CAPACITY_RESET;
    logic [WORD_W-1:0] type_mask_q = TYPE_MASK_RESET;
    logic [WORD_W-1:0] debug_type_q = DEBUG_TYPE_RESET;

    t_journal_entry pending_entries [$];
    t_journal_entry typed_entry;
    t_row_check     play_check = CHK_MODEL;
    bit             no_idle = 1'b0;
    int             error_count = 0;
    int             quiet_cycles = 0;

    function automatic int unsigned ring_len();
        return (capacity_q > JOURNAL_DEPTH) ? JOURNAL_DEPTH : int'(capacity_q);
    endfunction

    function automatic bit log_dropped(input logic [WORD_W-1:0] t);
        return ((t & type_mask_q) == debug_type_q) || (ring_len() == 0);
    endfunction

    function automatic void journal_config(input logic [REG_IDX_W-1:0] idx,
                                           input logic [WORD_W-1:0] d);
        case (idx)
            REG_CAPACITY: begin
                capacity_q = d[CAP_W-1:0];
                oldest_ptr = 0;
                write_ptr  = 0;
            end
            REG_TYPE_MASK:  type_mask_q = d;
            REG_DEBUG_TYPE: debug_type_q = d;
            default: ;
        endcase
    endfunction

    function automatic void journal_log(input logic [WORD_W-1:0] t, v, n);
        int unsigned len;
        int unsigned slot;
        len = ring_len();
        if (log_dropped(t)) return;
        slot = write_ptr % len;
        shadow_type[slot]  = t;
        shadow_value[slot] = v;
        shadow_inst[slot]  = n;
        write_ptr = (slot + 1) % len;
        if (write_ptr == oldest_ptr % len)
            oldest_ptr = (oldest_ptr % len + 1) % len;
    endfunction

    function automatic void journal_playback();
        int unsigned len;
        int unsigned pos;
        int unsigned count;
        t_journal_entry e;
        len = ring_len();
        if (len == 0) return;
        pos   = oldest_ptr % len;
        count = (write_ptr % len + len - pos) % len;
        for (int unsigned k = 0; k < count; k++) begin
            e.etype  = shadow_type[pos];
            e.evalue = shadow_value[pos];
            e.einst  = shadow_inst[pos];
            e.last   = (k + 1 == count);
            pending_entries.push_back(e);
            pos = (pos + 1) % len;
        end
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : journal_monitor
        t_journal_entry want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_entries.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected entry, expected none, actual %h %h %h %b",
                             $time, o_entry_type, o_entry_value, o_entry_instance,
                             o_last_of_run);
                end else begin
                    want = pending_entries.pop_front();
                    check_field("entry_type", want.etype, o_entry_type);
                    check_field("entry_value", want.evalue, o_entry_value);
                    check_field("entry_instance", want.einst, o_entry_instance);
                    check_field("last_of_run", WORD_W'(want.last), WORD_W'(o_last_of_run));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                journal_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                if (i_action == ACT_PLAY) begin
                    case (play_check)
                        CHK_MODEL: journal_playback();
                        CHK_ONE:   pending_entries.push_back(typed_entry);
                        default: ;
                    endcase
                end else begin
                    journal_log(i_code_type, i_code_value, i_instance_number);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_backpressure
        int unsigned hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic act, input logic [WORD_W-1:0] t, v, n);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_action          <= act;
        i_code_type       <= t;
        i_code_value      <= v;
        i_instance_number <= n;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d,
                             input bit hold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (!hold) i_cfg_valid <= 1'b0;
    endtask

    task automatic settle(input int cycles);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_entries.size() != 0);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic random_log(input bit keep);
        logic [WORD_W-1:0] t;
        t = $urandom();
        if (keep && log_dropped(t)) t = t ^ ((~t & type_mask_q) | (t & type_mask_q));
        if (keep && log_dropped(t)) t = debug_type_q ^ 32'h0000_0001;
        send_item(ACT_LOG, t, $urandom(), $urandom());
    endtask

    initial begin : stimulus
        t_stim_row         row;
        int                random_items;
        int                phase_len;
        logic [WORD_W-1:0] t;
        logic [CAP_W-1:0]  cap;
        bit                play;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    if (r == 0 || directed_rows[r-1].kind != ROW_CFG) settle(DRAIN_CYCLES);
                    cfg_write(row.idx, row.w0,
                              (r + 1 < N_ROWS) && (directed_rows[r+1].kind == ROW_CFG));
                end
                ROW_LOG: send_item(ACT_LOG, row.w0, row.w1, row.w2);
                default: begin
                    play_check  = row.chk;
                    typed_entry = {row.w0, row.w1, row.w2, 1'b1};
                    send_item(ACT_PLAY, $urandom(), $urandom(), $urandom());
                end
            endcase
        end

        play_check   = CHK_MODEL;
        random_items = 0;
        while (random_items < 20) begin
            settle(DRAIN_CYCLES);
            case ($urandom_range(0, 9))
                0:       cap = 7'd1;
                1:       cap = 7'd2;
                2:       cap = 7'd64;
                3:       cap = 7'($urandom_range(65, 127));
                default: cap = 7'($urandom_range(3, 16));
            endcase
            if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom(), 1'b1);
            t = ($urandom_range(0, 1) == 0) ? TYPE_MASK_RESET : $urandom();
            cfg_write(REG_TYPE_MASK, t, 1'b1);
            cfg_write(REG_DEBUG_TYPE, ($urandom_range(0, 4) == 0) ? $urandom() : ($urandom() & t),
                      1'b1);
            cfg_write(REG_CAPACITY, {25'($urandom()), cap}, 1'b0);
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(4, 10);
            for (int k = 0; k < phase_len; k++) begin
                play = ($urandom_range(0, 4) == 0);
                if (play) begin
                    random_items++;
                    send_item(ACT_PLAY, $urandom(), $urandom(), $urandom());
                end else begin
                    t = $urandom();
                    if ($urandom_range(0, 6) == 0)
                        t = ($urandom() & ~type_mask_q) | debug_type_q;
                    if (!log_dropped(t)) random_items++;
                    send_item(ACT_LOG, t, $urandom(), $urandom());
                end
            end
        end

        // Fill a full-depth ring past its size so that playback returns every held entry.
        settle(DRAIN_CYCLES);
        no_idle = 1'b0;
        cfg_write(REG_TYPE_MASK, TYPE_MASK_RESET, 1'b1);
        cfg_write(REG_DEBUG_TYPE, DEBUG_TYPE_RESET, 1'b1);
        cfg_write(REG_CAPACITY, {25'($urandom()), 7'd64}, 1'b0);
        for (int k = 0; k < 65; k++) random_log(1'b1);
        send_item(ACT_PLAY, $urandom(), $urandom(), $urandom());
        for (int k = 0; k < 2; k++) random_log(1'b1);
        send_item(ACT_PLAY, $urandom(), $urandom(), $urandom());

        settle(2 * DRAIN_CYCLES);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/ovjr_pkg.sv
hdl/ovjr_ctrl.sv
hdl/ovjr_datapath.sv
hdl/overwriting_event_journal_ring_unit.sv
tb/tb_overwriting_event_journal_ring_unit.sv
